### hw/rtl/pdlra_pkg.sv
// Package for the proximity dark/light ratio alarm.
// Holds sizes, the lane control and alarm status structs, and the control
// state type. No dependencies.
package pdlra_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int RATIO_BITS  = 10;

    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(30);

    // Ten times a dark reading, built as (d << 3) + (d << 1).
    localparam int SCALED_BITS = SAMPLE_BITS + 4;
    // Threshold times (light + 1).
    localparam int PROD_BITS   = RATIO_BITS + SAMPLE_BITS + 1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [RATIO_BITS-1:0]  ratio_t;
    typedef logic [CHANNELS-1:0]    chan_mask_t;

    typedef struct packed {
        logic capture_dark;
        logic capture_light;
    } lane_ctrl_t;

    typedef struct packed {
        chan_mask_t mask;
        logic       flag;
    } alarm_status_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RESULT
    } ctl_state_t;

endpackage

### hw/rtl/pdlra_lane.sv
// One channel lane of the proximity dark/light ratio alarm.
// Stores the dark reading and tests dark*10/(light+1) < threshold without a
// divider. Depends on pdlra_pkg.
module pdlra_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdlra_pkg::lane_ctrl_t ctrl,
    input  pdlra_pkg::sample_t   sample,
    input  pdlra_pkg::ratio_t    ratio,
    output logic                 below
);

    pdlra_pkg::sample_t                  dark_reg;
    logic [pdlra_pkg::PROD_BITS-1:0]     prod_reg;
    logic [pdlra_pkg::PROD_BITS-1:0]     prod_next;
    logic [pdlra_pkg::SAMPLE_BITS:0]     divisor;
    logic [pdlra_pkg::SCALED_BITS-1:0]   scaled_dark;

    // For a nonzero divisor, floor(n / d) < r holds exactly when n < r * d.
    assign divisor   = {1'b0, sample} + (pdlra_pkg::SAMPLE_BITS+1)'(1);
    assign prod_next = pdlra_pkg::PROD_BITS'(ratio) * pdlra_pkg::PROD_BITS'(divisor);

    assign scaled_dark = (pdlra_pkg::SCALED_BITS'(dark_reg) << 3)
                       + (pdlra_pkg::SCALED_BITS'(dark_reg) << 1);

    assign below = pdlra_pkg::PROD_BITS'(scaled_dark) < prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg <= '0;
        end
        else if (ctrl.capture_dark)
        begin
            dark_reg <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture_light)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

### hw/rtl/pdlra_merge.sv
// Merging stage of the proximity dark/light ratio alarm.
// Collects the lane decisions into the held alarm mask and flag.
// Depends on pdlra_pkg.
module pdlra_merge (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     update,
    input  pdlra_pkg::chan_mask_t    lane_below,
    output pdlra_pkg::alarm_status_t status_next
);

    pdlra_pkg::chan_mask_t mask_reg;
    pdlra_pkg::chan_mask_t mask_next;
    logic                  flag_reg;
    logic                  flag_next;

    // Dark phases leave the mask and flag as they were.
    assign mask_next = update ? lane_below : mask_reg;
    assign flag_next = update ? (|lane_below) : flag_reg;

    assign status_next.mask = mask_next;
    assign status_next.flag = flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            flag_reg <= flag_next;
        end
    end

    a_hold_in_dark: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> (mask_reg == $past(mask_reg)) && (flag_reg == $past(flag_reg)))
        else $error("alarm state changed without a lit update");

    a_flag_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg == (mask_reg != '0))
        else $error("alarm flag disagrees with alarm mask");

endmodule

### hw/rtl/proximity_dark_light_ratio_alarm.sv
// Top level of the proximity dark/light ratio alarm: control, lanes, merge
// and the result register. Depends on pdlra_pkg, pdlra_lane and pdlra_merge.
//
//   port group      direction  handshake              payload
//   input set       in         in_valid / in_stall    sample_ch0..sample_ch3
//   result          out        out_valid / out_stall  emitter_on, channel_alarms,
//                                                     any_alarm, motor_enable
//   threshold reg   in         alarm_ratio_we         alarm_ratio_wdata
//
// An item passes through both states: the transfer in the idle state stores the dark
// readings or registers the lane products, and the result state then compares and loads
// the result register. A new set is taken once the previous result is loaded. A waiting
// result holds the block in its result state until the register frees. Reset clears the
// dark readings and the merge's held alarm mask and flag, and sets the threshold to 30.
// The emitter and result outputs are not reset.
module proximity_dark_light_ratio_alarm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [pdlra_pkg::SAMPLE_BITS-1:0] sample_ch0,
    input  logic [pdlra_pkg::SAMPLE_BITS-1:0] sample_ch1,
    input  logic [pdlra_pkg::SAMPLE_BITS-1:0] sample_ch2,
    input  logic [pdlra_pkg::SAMPLE_BITS-1:0] sample_ch3,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       emitter_on,
    output logic [pdlra_pkg::CHANNELS-1:0] channel_alarms,
    output logic                       any_alarm,
    output logic                       motor_enable,
    input  logic                       alarm_ratio_we,
    input  logic [pdlra_pkg::RATIO_BITS-1:0] alarm_ratio_wdata
);

    pdlra_pkg::ctl_state_t    state_reg;
    pdlra_pkg::ctl_state_t    state_next;
    pdlra_pkg::ratio_t        ratio_reg;
    logic                     phase_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     emitter_on_reg;
    pdlra_pkg::chan_mask_t    channel_alarms_reg;
    logic                     any_alarm_reg;

    logic                     accept;
    logic                     load;
    pdlra_pkg::lane_ctrl_t    lane_ctrl;
    pdlra_pkg::sample_t       samples [pdlra_pkg::CHANNELS];
    pdlra_pkg::chan_mask_t    lane_below;
    pdlra_pkg::alarm_status_t status_next;

    assign samples[0] = sample_ch0;
    assign samples[1] = sample_ch1;
    assign samples[2] = sample_ch2;
    assign samples[3] = sample_ch3;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdlra_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pdlra_pkg::ST_RESULT;
                end
            end
            pdlra_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = pdlra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdlra_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall = 1'b1;
        load     = 1'b0;
        case (state_reg)
            pdlra_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            pdlra_pkg::ST_RESULT:
            begin
                load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept                  = in_valid && !in_stall;
    assign lane_ctrl.capture_dark  = accept && !phase_reg;
    assign lane_ctrl.capture_light = accept && phase_reg;

    assign out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);

    for (genvar i = 0; i < pdlra_pkg::CHANNELS; i++)
    begin : g_lane
        pdlra_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .sample (samples[i]),
            .ratio  (ratio_reg),
            .below  (lane_below[i])
        );
    end

    pdlra_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (load && phase_reg),
        .lane_below  (lane_below),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdlra_pkg::ST_IDLE;
            ratio_reg     <= pdlra_pkg::RATIO_RESET;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (alarm_ratio_we)
            begin
                ratio_reg <= alarm_ratio_wdata;
            end
            if (load)
            begin
                phase_reg <= !phase_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            emitter_on_reg     <= !phase_reg;
            channel_alarms_reg <= status_next.mask;
            any_alarm_reg      <= status_next.flag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign emitter_on     = emitter_on_reg;
    assign channel_alarms = channel_alarms_reg;
    assign any_alarm      = any_alarm_reg;
    assign motor_enable   = !any_alarm_reg;

    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == pdlra_pkg::ST_RESULT)
        else $error("transfer did not lead to the result cycle");

    a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (phase_reg != $past(phase_reg)) && out_valid_reg)
        else $error("result load did not toggle the emitter phase");

    a_emitter_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && state_reg == pdlra_pkg::ST_IDLE |-> emitter_on_reg == phase_reg)
        else $error("reported emitter state differs from the phase");

    a_alarm_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> any_alarm_reg == (channel_alarms_reg != '0))
        else $error("overall alarm disagrees with channel alarms");

endmodule
